// ===== rtl/jsq_pkg.sv =====
// Shared types and constants of the shortest-queue dispatcher.
`default_nettype none
package jsq_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_JOIN  = 2'd1,
    REQ_CLOSE = 2'd2,
    REQ_OPEN  = 2'd3
  } req_kind_e;

  typedef enum logic [1:0] {
    RES_DONE   = 2'd0,
    RES_PLACED = 2'd1,
    RES_REJECT = 2'd2
  } res_kind_e;

  localparam int TagW  = 16;
  localparam int SvcW  = 16;
  localparam int IdxW  = 3;
  localparam int TimeW = 32;

  // Request as handed from the front to the back.
  typedef struct packed {
    req_kind_e         kind;
    logic [TagW-1:0]   tag;
    logic [SvcW-1:0]   svc;
    logic [IdxW-1:0]   idx;
    logic              idx_ok;   // server index names an existing server
  } req_t;

  typedef struct packed {
    res_kind_e         kind;
    logic [TagW-1:0]   tag;
    logic [IdxW-1:0]   server;
    logic [TimeW-1:0]  ftime;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/jsq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module jsq_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jsq_front.sv =====
// Front end: accept request items, classify them and queue them for the engine.
`default_nettype none
module jsq_front #(
  parameter int SERVERS = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  input  wire logic [1:0]    s_user_i,
  input  wire logic [39:0]   s_data_i,
  input  wire logic          pop_i,
  output logic               req_valid_o,
  output jsq_pkg::req_t      req_o
);
  import jsq_pkg::*;

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  req_t            buf_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   fill_q;
  req_t            in_req;
  logic            push, pop;

  always_comb begin
    in_req.kind   = req_kind_e'(s_user_i);
    in_req.tag    = s_data_i[15:0];
    in_req.svc    = s_data_i[31:16];
    in_req.idx    = s_data_i[34:32];
    in_req.idx_ok = (32'(s_data_i[34:32]) < 32'(SERVERS));
  end

  assign s_ready_o   = (fill_q != (PtrW+1)'(Depth));
  assign req_valid_o = (fill_q != '0);
  assign req_o       = buf_q[rptr_q];
  assign push        = s_valid_i && s_ready_o;
  assign pop         = pop_i && req_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= in_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + PtrW'(1);
      if (pop)  rptr_q <= rptr_q + PtrW'(1);
      if (push && !pop)      fill_q <= fill_q + (PtrW+1)'(1);
      else if (pop && !push) fill_q <= fill_q - (PtrW+1)'(1);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jsq_engine.sv =====
// Back end: sequencer that runs ticks, joins, closes and opens over the server queues.
`default_nettype none
module jsq_engine #(
  parameter int SERVERS     = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [3:0]    cfg_wdata_i,
  input  wire logic          req_valid_i,
  input  wire jsq_pkg::req_t req_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output jsq_pkg::result_t   out_o,
  output logic               out_last_o
);
  import jsq_pkg::*;

  localparam int SW  = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int IW  = SW + 1;
  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int KW  = $clog2(QUEUE_DEPTH + 1);
  localparam int TW  = KW + 1;
  localparam int AW  = SW + PW;
  localparam int LIM = (SERVERS < 8) ? SERVERS : 8;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_JOIN    = 4'd2;
  localparam logic [3:0] S_TK_CHK  = 4'd3;
  localparam logic [3:0] S_TK_WAIT = 4'd4;
  localparam logic [3:0] S_TK_EVAL = 4'd5;
  localparam logic [3:0] S_TK_END  = 4'd6;
  localparam logic [3:0] S_CL_CHK  = 4'd7;
  localparam logic [3:0] S_CL_T    = 4'd8;
  localparam logic [3:0] S_CL_RA   = 4'd9;
  localparam logic [3:0] S_CL_R1   = 4'd10;
  localparam logic [3:0] S_CL_R2   = 4'd11;
  localparam logic [3:0] S_CL_W    = 4'd12;

  logic [KW-1:0]      cnt_q  [SERVERS];
  logic [PW-1:0]      head_q [SERVERS];
  logic [15:0]        el_q   [SERVERS];
  logic [SERVERS-1:0] open_q;
  logic [31:0]        tick_q;
  logic [3:0]         active_q;
  logic [3:0]         state_q, ret_q;
  logic [IW-1:0]      i_q;
  logic [SW-1:0]      best_q;
  logic [KW-1:0]      bestcnt_q;
  logic               found_q;
  req_t               cur_q;
  logic [31:0]        moved_q;
  logic               pend_vld_q;
  result_t            pend_q;
  logic               out_vld_q, out_last_q;
  result_t            out_q;

  logic [IW-1:0]  used;
  logic           i_end, out_free, full;
  logic [SW-1:0]  sel, idx_s;
  logic [KW-1:0]  s_cnt;
  logic [PW-1:0]  s_head, head_inc, tail_p;
  logic [15:0]    s_el, el_inc;
  logic [TW-1:0]  tail_w, tail;
  logic           re, we;
  logic [AW-1:0]  raddr, waddr;
  logic [31:0]    wdata, rdata;

  always_comb begin
    if (active_q == 4'd0) begin
      used = IW'(1);
    end else if ({1'b0, active_q} > 5'(LIM)) begin
      used = IW'(LIM);
    end else begin
      used = IW'(active_q);
    end
  end

  assign i_end    = (i_q >= used);
  assign out_free = !out_vld_q || out_ready_i;
  assign idx_s    = SW'(cur_q.idx);

  always_comb begin
    case (state_q)
      S_SCAN, S_TK_CHK, S_TK_WAIT, S_TK_EVAL: sel = i_q[SW-1:0];
      S_CL_CHK, S_CL_RA, S_CL_R1, S_CL_R2:    sel = idx_s;
      default:                                sel = best_q;
    endcase
  end

  assign s_cnt    = cnt_q[sel];
  assign s_head   = head_q[sel];
  assign s_el     = el_q[sel];
  assign el_inc   = s_el + 16'd1;
  assign head_inc = (s_head == PW'(QUEUE_DEPTH - 1)) ? '0 : s_head + PW'(1);
  assign tail_w   = TW'(s_head) + TW'(s_cnt);
  assign tail     = (tail_w >= TW'(QUEUE_DEPTH)) ? tail_w - TW'(QUEUE_DEPTH) : tail_w;
  assign tail_p   = tail[PW-1:0];
  assign full     = (s_cnt == KW'(QUEUE_DEPTH));
  assign pop_o    = (state_q == S_IDLE) && req_valid_i;

  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = {sel, s_head};
    waddr = {sel, tail_p};
    wdata = {cur_q.tag, cur_q.svc};
    case (state_q)
      S_TK_CHK: re = !i_end && (s_cnt != '0);
      S_CL_RA: begin
        re    = 1'b1;
        raddr = {sel, head_inc};
      end
      S_CL_R1: re = 1'b1;
      S_CL_R2: begin
        we    = 1'b1;
        waddr = {sel, head_inc};
        wdata = rdata;
      end
      S_CL_W: begin
        we    = 1'b1;
        wdata = moved_q;
      end
      S_JOIN: we = out_free && !full;
      default: ;
    endcase
  end

  jsq_ram #(
    .Width (32),
    .Depth (SERVERS << PW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) cur_q <= req_i;
    if (state_q == S_CL_R1) moved_q <= rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SERVERS; k++) begin
        cnt_q[k]  <= '0;
        head_q[k] <= '0;
        el_q[k]   <= '0;
      end
      open_q     <= '1;
      tick_q     <= '0;
      active_q   <= 4'd8;
      state_q    <= S_IDLE;
      ret_q      <= S_IDLE;
      i_q        <= '0;
      best_q     <= '0;
      bestcnt_q  <= '0;
      found_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      pend_q     <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
      out_q      <= '0;
    end else begin
      if (cfg_we_i) active_q <= cfg_wdata_i;
      if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            i_q     <= '0;
            found_q <= 1'b0;
            best_q  <= '0;
            case (req_i.kind)
              REQ_TICK: begin
                tick_q  <= tick_q + 32'd1;
                state_q <= S_TK_CHK;
              end
              REQ_JOIN: begin
                ret_q   <= S_JOIN;
                state_q <= S_SCAN;
              end
              REQ_CLOSE: begin
                if (req_i.idx_ok) begin
                  open_q[SW'(req_i.idx)] <= 1'b0;
                  state_q <= S_CL_CHK;
                end
              end
              default: begin
                if (req_i.idx_ok) open_q[SW'(req_i.idx)] <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (i_end) begin
            state_q <= ret_q;
          end else begin
            if (open_q[sel] && (!found_q || s_cnt < bestcnt_q)) begin
              best_q    <= sel;
              bestcnt_q <= s_cnt;
              found_q   <= 1'b1;
            end
            i_q <= i_q + IW'(1);
          end
        end
        S_JOIN: begin
          if (out_free) begin
            out_vld_q     <= 1'b1;
            out_last_q    <= 1'b1;
            out_q.kind    <= full ? RES_REJECT : RES_PLACED;
            out_q.tag     <= cur_q.tag;
            out_q.server  <= IdxW'(best_q);
            out_q.ftime   <= '0;
            if (!full) cnt_q[sel] <= s_cnt + KW'(1);
            state_q <= S_IDLE;
          end
        end
        S_TK_CHK: begin
          if (i_end) begin
            state_q <= S_TK_END;
          end else if (s_cnt == '0) begin
            i_q <= i_q + IW'(1);
          end else begin
            state_q <= S_TK_WAIT;
          end
        end
        S_TK_WAIT: state_q <= S_TK_EVAL;
        S_TK_EVAL: begin
          if (el_inc >= rdata[15:0]) begin
            // Front job done: hold it as pending so the final one gets last.
            if (!pend_vld_q || out_free) begin
              if (pend_vld_q) begin
                out_vld_q  <= 1'b1;
                out_last_q <= 1'b0;
                out_q      <= pend_q;
              end
              pend_vld_q    <= 1'b1;
              pend_q.kind   <= RES_DONE;
              pend_q.tag    <= rdata[31:16];
              pend_q.server <= IdxW'(sel);
              pend_q.ftime  <= tick_q;
              head_q[sel]   <= head_inc;
              cnt_q[sel]    <= s_cnt - KW'(1);
              el_q[sel]     <= '0;
              i_q           <= i_q + IW'(1);
              state_q       <= S_TK_CHK;
            end
          end else begin
            el_q[sel] <= el_inc;
            i_q       <= i_q + IW'(1);
            state_q   <= S_TK_CHK;
          end
        end
        S_TK_END: begin
          if (!pend_vld_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_vld_q  <= 1'b1;
            out_last_q <= 1'b1;
            out_q      <= pend_q;
            pend_vld_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        S_CL_CHK: begin
          if (s_cnt > KW'(1)) begin
            i_q     <= '0;
            found_q <= 1'b0;
            best_q  <= '0;
            ret_q   <= S_CL_T;
            state_q <= S_SCAN;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_CL_T: begin
          if (best_q == idx_s || full) state_q <= S_IDLE;
          else                         state_q <= S_CL_RA;
        end
        S_CL_RA: state_q <= S_CL_R1;
        S_CL_R1: state_q <= S_CL_R2;
        S_CL_R2: begin
          head_q[sel] <= head_inc;
          cnt_q[sel]  <= s_cnt - KW'(1);
          state_q     <= S_CL_W;
        end
        S_CL_W: begin
          cnt_q[sel] <= s_cnt + KW'(1);
          state_q    <= S_CL_CHK;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;
  assign out_last_o  = out_last_q;

  a_join_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_JOIN && out_free) |=> (out_vld_q && out_last_q))
    else $error("join did not produce a final result");

  a_pend_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> (state_q == S_TK_CHK || state_q == S_TK_WAIT ||
                    state_q == S_TK_EVAL || state_q == S_TK_END))
    else $error("pending finish outside a tick");

  a_move_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CL_W) |-> (best_q != idx_s))
    else $error("move targets the closed server");

endmodule
`default_nettype wire

// ===== rtl/shortest_queue_server_dispatcher.sv =====
// Top level of the join-shortest-queue dispatcher.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+----------------------------------
//  s_axis    | in        | tvalid/tready         | tuser req_type, tdata job fields
//  m_axis    | out       | tvalid/tready, tlast  | tuser result_kind, tdata result
//  cfg       | in        | cfg_we_i              | cfg_wdata_i active_servers
//
// Sequencing: open is handled in the idle state; join scans the used servers for
// the shortest open queue; a tick walks the used servers and reads the front job
// of each busy one; close moves jobs off the closed server, scanning before each
// move, until one job is left or the moves stop on the closed server or a full target.
// Reset: asynchronous, all queues empty, all servers open, active_servers 8.
// Stalls: a 4-item request queue decouples input from the engine; results sit
// in an output register, and the engine waits only when that register is full.
`default_nettype none
module shortest_queue_server_dispatcher #(
  parameter int SERVERS     = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [1:0]  s_axis_tuser_i,   // req_type
  input  wire logic [39:0] s_axis_tdata_i,   // job_tag, service_time, server_index
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [1:0]       m_axis_tuser_o,   // result_kind
  output logic [55:0]      m_axis_tdata_o,   // result_tag, result_server, finish_time
  output logic             m_axis_tlast_o,   // last
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i       // active_servers
);
  import jsq_pkg::*;

  req_t    req;
  logic    req_valid, pop;
  result_t res;

  // Accept and classify requests, queue them for the engine.
  jsq_front #(
    .SERVERS (SERVERS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_user_i    (s_axis_tuser_i),
    .s_data_i    (s_axis_tdata_i),
    .pop_i       (pop),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  // Carry out each request against the server queues.
  jsq_engine #(
    .SERVERS     (SERVERS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (req_valid),
    .req_i       (req),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res),
    .out_last_o  (m_axis_tlast_o)
  );

  // Pack the result: tag lowest, then server, then finish time.
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tdata_o = {5'd0, res.ftime, res.server, res.tag};

endmodule
`default_nettype wire

// ===== tb/shortest_queue_server_dispatcher_test.sv =====
// Self-checking testbench for the join-shortest-queue dispatcher.
module shortest_queue_server_dispatcher_test;
  timeunit 1ns;
  timeprecision 1ps;
  import jsq_pkg::*;

  localparam int NumSrv   = 8;
  localparam int Depth    = 64;
  // Longest quiet stretch: a close that moves a whole queue, times the request queue.
  localparam int DrainCyc = 6000;
  localparam int IdleMax  = 40000;

  typedef struct {
    res_kind_e   kind;
    logic [15:0] tag;
    logic [2:0]  server;
    logic [31:0] ftime;
    logic        last;
  } disp_result_t;

  // Tracks queue contents and holds the results the block still owes.
  class dispatch_scoreboard;
    logic [15:0]  tag_mem[NumSrv][Depth];
    logic [15:0]  svc_mem[NumSrv][Depth];
    int           heads[NumSrv];
    int           counts[NumSrv];
    logic [15:0]  elapsed[NumSrv];
    bit           is_open[NumSrv];
    logic [31:0]  ticks;
    logic [3:0]   active;
    disp_result_t owed[$];
    int           errors;

    function new();
      for (int i = 0; i < NumSrv; i++) begin
        heads[i] = 0; counts[i] = 0; elapsed[i] = 0; is_open[i] = 1;
      end
      ticks = 0; active = 4'd8; errors = 0;
    endfunction

    function void set_active(logic [3:0] v);
      active = v;
    endfunction

    function int used();
      int a;
      a = active;
      if (a < 1) a = 1;
      if (a > NumSrv) a = NumSrv;
      return a;
    endfunction

    // Shortest open queue, ties to the lowest index, server 0 if none is open.
    function int shortest_open();
      int best;
      bit found;
      best = 0; found = 0;
      for (int i = 0; i < used(); i++)
        if (is_open[i] && (!found || counts[i] < counts[best])) begin
          best = i; found = 1;
        end
      return best;
    endfunction

    function void push_tail(int s, logic [15:0] t, logic [15:0] sv);
      tag_mem[s][(heads[s] + counts[s]) % Depth] = t;
      svc_mem[s][(heads[s] + counts[s]) % Depth] = sv;
      counts[s]++;
    endfunction

    function void note_request(req_kind_e req, logic [15:0] tag, logic [15:0] svc,
                               logic [2:0] idx);
      disp_result_t r[$];
      disp_result_t one;
      int t, h, m;
      case (req)
        REQ_TICK: begin
          ticks = ticks + 1;
          for (int i = 0; i < used(); i++) begin
            if (counts[i] == 0) continue;
            elapsed[i] = elapsed[i] + 16'd1;
            if (elapsed[i] >= svc_mem[i][heads[i]]) begin
              one = '{RES_DONE, tag_mem[i][heads[i]], 3'(i), ticks, 1'b0};
              r.push_back(one);
              heads[i] = (heads[i] + 1) % Depth;
              counts[i]--;
              elapsed[i] = 0;
            end
          end
        end
        REQ_JOIN: begin
          t = shortest_open();
          if (counts[t] >= Depth) begin
            one = '{RES_REJECT, tag, 3'(t), 32'd0, 1'b0};
          end else begin
            push_tail(t, tag, svc);
            one = '{RES_PLACED, tag, 3'(t), 32'd0, 1'b0};
          end
          r.push_back(one);
        end
        REQ_OPEN: is_open[idx] = 1;
        default: begin
          // Close: the second job leaves, the front one slides up into its slot.
          is_open[idx] = 0;
          while (counts[idx] > 1) begin
            t = shortest_open();
            if (t == idx || counts[t] >= Depth) break;
            h = heads[idx];
            m = (h + 1) % Depth;
            one.tag = tag_mem[idx][m];
            one.ftime = svc_mem[idx][m];
            tag_mem[idx][m] = tag_mem[idx][h];
            svc_mem[idx][m] = svc_mem[idx][h];
            heads[idx] = m;
            counts[idx]--;
            push_tail(t, one.tag, one.ftime[15:0]);
          end
        end
      endcase
      if (r.size() > 0) r[r.size()-1].last = 1'b1;
      foreach (r[k]) owed.push_back(r[k]);
    endfunction

    function void check_result(disp_result_t got);
      disp_result_t exp_r;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind %0d tag %h server %0d time %0d last %0d",
                   got.kind, got.tag, got.server, got.ftime, got.last);
        return;
      end
      exp_r = owed.pop_front();
      if (got.kind !== exp_r.kind || got.tag !== exp_r.tag || got.server !== exp_r.server
          || got.ftime !== exp_r.ftime || got.last !== exp_r.last) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected kind %0d tag %h server %0d time %0d last %0d,",
                    " got kind %0d tag %h server %0d time %0d last %0d"},
                   exp_r.kind, exp_r.tag, exp_r.server, exp_r.ftime, exp_r.last,
                   got.kind, got.tag, got.server, got.ftime, got.last);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_valid, s_ready;
  logic [1:0]  s_user;
  logic [39:0] s_data;
  logic        m_valid, m_ready, m_last;
  logic [1:0]  m_user;
  logic [55:0] m_data;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  int          idle_cycles;
  dispatch_scoreboard sb;

  shortest_queue_server_dispatcher u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tuser_i  (s_user),   // req_type
    .s_axis_tdata_i  (s_data),   // job_tag, service_time, server_index
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tuser_o  (m_user),   // result_kind
    .m_axis_tdata_o  (m_data),   // result_tag, result_server, finish_time
    .m_axis_tlast_o  (m_last),   // last
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata) // active_servers
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap length: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one request item and hold it until the block takes it.
  task automatic send_req(req_kind_e req, logic [15:0] tag, logic [15:0] svc,
                          logic [2:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= req;
    s_data  <= {5'd0, idx, svc, tag};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sb.note_request(req, tag, svc, idx);
  endtask

  // Write active_servers once all owed results are in and the engine has settled.
  task automatic set_servers(logic [3:0] v);
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_active(v);
  endtask

  task automatic random_items(int n);
    int r;
    logic [15:0] svc;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 85) svc = 16'($urandom_range(0, 6));
      else if ($urandom_range(0, 9) < 8) svc = 16'($urandom_range(0, 40));
      else svc = 16'($urandom);
      if (r < 45) send_req(REQ_JOIN, 16'($urandom), svc, 3'($urandom));
      else if (r < 85) send_req(REQ_TICK, 16'($urandom), svc, 3'($urandom));
      else if (r < 93) send_req(REQ_CLOSE, 16'($urandom), svc, 3'($urandom));
      else send_req(REQ_OPEN, 16'($urandom), svc, 3'($urandom));
    end
  endtask

  // Receiver: runs of ready with random stalls between them.
  initial begin
    int run, gap;
    m_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(1, 12);
      m_ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Compare each accepted result with the oldest owed one.
  always @(posedge clk_i) begin
    disp_result_t got;
    if (rst_ni && m_valid && m_ready) begin
      got.kind   = res_kind_e'(m_user);
      got.tag    = m_data[15:0];
      got.server = m_data[18:16];
      got.ftime  = m_data[50:19];
      got.last   = m_last;
      sb.check_result(got);
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleMax) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    sb = new();
    rst_ni    = 1'b0;
    s_valid   = 1'b0;
    s_user    = '0;
    s_data    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, every request kind, close with moves.
    set_servers(4'd8);
    send_req(REQ_JOIN, 16'h0000, 16'h0000, 3'd0);
    send_req(REQ_JOIN, 16'hFFFF, 16'hFFFF, 3'd7);
    send_req(REQ_JOIN, 16'h1234, 16'd2, 3'd0);
    send_req(REQ_TICK, 16'hFFFF, 16'hFFFF, 3'd7);
    send_req(REQ_CLOSE, 16'h0, 16'h0, 3'd2);
    for (int k = 0; k < 8; k++) send_req(REQ_JOIN, 16'(16'hA000 + k), 16'd3, 3'd0);
    send_req(REQ_CLOSE, 16'h0, 16'h0, 3'd0);
    send_req(REQ_OPEN, 16'h0, 16'h0, 3'd0);
    send_req(REQ_OPEN, 16'h0, 16'h0, 3'd2);
    for (int k = 0; k < 4; k++) send_req(REQ_TICK, 16'h0, 16'h0, 3'd0);

    // One server: fill its queue until a join is rejected, close it with
    // nowhere to move jobs, then drain.
    set_servers(4'd1);
    for (int k = 0; k < Depth + 1; k++) send_req(REQ_JOIN, 16'(16'hB000 + k), 16'd1, 3'd0);
    send_req(REQ_CLOSE, 16'h0, 16'h0, 3'd0);
    send_req(REQ_JOIN, 16'hC0DE, 16'd1, 3'd5);
    send_req(REQ_OPEN, 16'h0, 16'h0, 3'd0);
    for (int k = 0; k < Depth + 2; k++) send_req(REQ_TICK, 16'h0, 16'h0, 3'd0);

    // Random phases across settings, including out-of-range register values.
    set_servers(4'd8);
    random_items(60);
    set_servers(4'd3);
    random_items(60);
    set_servers(4'd15);
    random_items(60);
    set_servers(4'd0);
    random_items(60);
    set_servers(4'd5);
    random_items(60);
    set_servers(4'd2);
    random_items(60);

    s_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
